// ----- rtl/core/tkpt_pkg.sv -----
// Shared constants, types and state encoding for the top-K peak tracker.
package tkpt_pkg;

  localparam int KEEP_COUNT = 100;
  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = $clog2(KEEP_COUNT);
  localparam int CHILD_W    = ADDR_W + 2;
  localparam int SUM_W      = SAMPLE_W + $clog2(KEEP_COUNT);

  // floor(sum / KEEP_COUNT) == (sum * RECIP) >> DIV_SHIFT for every sum below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(KEEP_COUNT);
  localparam int RECIP_W   = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT)
                                         + 64'(KEEP_COUNT) - 64'd1) / 64'(KEEP_COUNT));
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } heap_state_t;

  typedef struct packed {
    logic                valid;
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } heap_req_t;

  typedef struct packed {
    logic                done;
    logic                accepted;
    logic [SAMPLE_W-1:0] min_kept;
  } heap_rsp_t;

endpackage

// ----- rtl/core/tkpt_if.sv -----
// Request and result channel interfaces of the top-K peak tracker.
interface tkpt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tkpt_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface tkpt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [tkpt_pkg::SAMPLE_W-1:0] min_kept;
  logic [tkpt_pkg::SAMPLE_W-1:0] average_kept;

  modport source (output valid, output accepted, output min_kept, output average_kept,
                  input ready);
  modport sink   (input valid, input accepted, input min_kept, input average_kept,
                  output ready);
endinterface

// ----- rtl/core/tkpt_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module tkpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/tkpt_heap.sv -----
// Min-heap controller: root compare, running sum and level-by-level sift-down in RAM.
module tkpt_heap (
  input  logic                         clk,
  input  logic                         rst,
  input  tkpt_pkg::heap_req_t          req,
  output logic                         ready,
  input  logic                         take,
  output tkpt_pkg::heap_rsp_t          rsp,
  output logic [tkpt_pkg::SUM_W-1:0]   sum
);

  tkpt_pkg::heap_state_t state, state_next;

  logic [tkpt_pkg::ADDR_W-1:0]   pos;
  logic [tkpt_pkg::SAMPLE_W-1:0] moving;
  logic                          accepted;
  logic [tkpt_pkg::SAMPLE_W-1:0] root;
  logic [tkpt_pkg::KEEP_COUNT-1:0] valid;
  logic                          has_right;
  logic                          ok_l;
  logic                          ok_r;

  logic                          we;
  logic [tkpt_pkg::ADDR_W-1:0]   waddr;
  logic [tkpt_pkg::SAMPLE_W-1:0] wdata;
  logic [tkpt_pkg::ADDR_W-1:0]   raddr_a;
  logic [tkpt_pkg::ADDR_W-1:0]   raddr_b;
  logic [tkpt_pkg::SAMPLE_W-1:0] rdata_a;
  logic [tkpt_pkg::SAMPLE_W-1:0] rdata_b;

  logic [tkpt_pkg::CHILD_W-1:0]  left_idx;
  logic [tkpt_pkg::CHILD_W-1:0]  right_idx;
  logic                          left_exists;
  logic                          right_exists;
  logic [tkpt_pkg::SAMPLE_W-1:0] left_val;
  logic [tkpt_pkg::SAMPLE_W-1:0] right_val;
  logic                          pick_right;
  logic [tkpt_pkg::SAMPLE_W-1:0] kid_val;
  logic [tkpt_pkg::ADDR_W-1:0]   kid_addr;
  logic                          go_down;
  logic                          hit;

  tkpt_ram #(
    .WIDTH (tkpt_pkg::SAMPLE_W),
    .DEPTH (tkpt_pkg::KEEP_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign left_idx     = {1'b0, pos, 1'b1};
  assign right_idx    = left_idx + tkpt_pkg::CHILD_W'(1);
  assign left_exists  = left_idx < tkpt_pkg::CHILD_W'(tkpt_pkg::KEEP_COUNT);
  assign right_exists = right_idx < tkpt_pkg::CHILD_W'(tkpt_pkg::KEEP_COUNT);

  // entries never written read as zero
  assign left_val   = ok_l ? rdata_a : '0;
  assign right_val  = ok_r ? rdata_b : '0;
  assign pick_right = has_right && (right_val < left_val);
  assign kid_val    = pick_right ? right_val : left_val;
  assign kid_addr   = pick_right ? right_idx[tkpt_pkg::ADDR_W-1:0]
                                 : left_idx[tkpt_pkg::ADDR_W-1:0];
  assign go_down    = kid_val < moving;
  assign hit        = (req.kind == tkpt_pkg::KIND_INSERT) && (req.sample > root);

  always_comb begin
    state_next = state;
    unique case (state)
      tkpt_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = hit ? tkpt_pkg::ST_READ : tkpt_pkg::ST_DONE;
        end
      end
      tkpt_pkg::ST_READ: begin
        state_next = left_exists ? tkpt_pkg::ST_CMP : tkpt_pkg::ST_DONE;
      end
      tkpt_pkg::ST_CMP: begin
        state_next = go_down ? tkpt_pkg::ST_READ : tkpt_pkg::ST_DONE;
      end
      tkpt_pkg::ST_DONE: begin
        if (take) begin
          state_next = tkpt_pkg::ST_IDLE;
        end
      end
      default: state_next = tkpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ready        = 1'b0;
    we           = 1'b0;
    waddr        = pos;
    wdata        = moving;
    raddr_a      = left_idx[tkpt_pkg::ADDR_W-1:0];
    raddr_b      = right_exists ? right_idx[tkpt_pkg::ADDR_W-1:0]
                                : left_idx[tkpt_pkg::ADDR_W-1:0];
    rsp.done     = 1'b0;
    rsp.accepted = accepted;
    rsp.min_kept = root;
    unique case (state)
      tkpt_pkg::ST_IDLE: ready = 1'b1;
      tkpt_pkg::ST_READ: begin
        // leaf reached: drop the moving value here
        we = !left_exists;
      end
      tkpt_pkg::ST_CMP: begin
        we    = 1'b1;
        wdata = go_down ? kid_val : moving;
      end
      tkpt_pkg::ST_DONE: rsp.done = take;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkpt_pkg::ST_IDLE;
      valid <= '0;
      root  <= '0;
      sum   <= '0;
    end else begin
      state <= state_next;
      if (we) begin
        valid[waddr] <= 1'b1;
        if (waddr == '0) begin
          root <= wdata;
        end
      end
      if (state == tkpt_pkg::ST_IDLE && req.valid && hit) begin
        sum <= sum - tkpt_pkg::SUM_W'(root) + tkpt_pkg::SUM_W'(req.sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tkpt_pkg::ST_IDLE && req.valid) begin
      accepted <= hit;
      moving   <= req.sample;
      pos      <= '0;
    end
    if (state == tkpt_pkg::ST_READ) begin
      has_right <= right_exists;
      ok_l      <= valid[left_idx[tkpt_pkg::ADDR_W-1:0]];
      ok_r      <= right_exists && valid[right_idx[tkpt_pkg::ADDR_W-1:0]];
    end
    if (state == tkpt_pkg::ST_CMP && go_down) begin
      pos <= kid_addr;
    end
  end

endmodule

// ----- rtl/core/tkpt_avg.sv -----
// Average of kept values: sum times a fixed reciprocal of the heap size, registered.
module tkpt_avg (
  input  logic                          clk,
  input  logic [tkpt_pkg::SUM_W-1:0]    sum,
  output logic [tkpt_pkg::SAMPLE_W-1:0] average
);

  logic [tkpt_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= tkpt_pkg::PROD_W'(sum) * tkpt_pkg::PROD_W'(tkpt_pkg::RECIP);
  end

  assign average = prod[tkpt_pkg::DIV_SHIFT +: tkpt_pkg::SAMPLE_W];

endmodule

// ----- rtl/core/top_k_peak_tracker.sv -----
// Top-K peak tracker: keeps the largest samples in a RAM-based min-heap.
// A query or a sample not above the minimum goes from ST_IDLE to ST_DONE and then into the
// output register. An accepted sample passes ST_READ and ST_CMP for each heap level compared
// and is written in ST_CMP or, at a leaf, in ST_READ before ST_DONE.
// One item at a time; a result may wait.
// Reset: synchronous, clears the heap (per-entry valid bits), the sum and the output.
module top_k_peak_tracker (
  input  logic            clk,
  input  logic            rst,
  tkpt_req_if.sink        req,
  tkpt_rsp_if.source      rsp
);

  tkpt_pkg::heap_req_t           heap_req;
  tkpt_pkg::heap_rsp_t           heap_rsp;
  logic                          heap_ready;
  logic                          take;
  logic [tkpt_pkg::SUM_W-1:0]    sum;
  logic [tkpt_pkg::SAMPLE_W-1:0] average;

  logic                          out_valid;
  logic                          out_accepted;
  logic [tkpt_pkg::SAMPLE_W-1:0] out_min;
  logic [tkpt_pkg::SAMPLE_W-1:0] out_avg;

  assign heap_req.valid  = req.valid;
  assign heap_req.kind   = req.kind;
  assign heap_req.sample = req.sample;
  assign req.ready       = heap_ready;
  assign take            = !out_valid || rsp.ready;

  tkpt_heap u_heap (
    .clk   (clk),
    .rst   (rst),
    .req   (heap_req),
    .ready (heap_ready),
    .take  (take),
    .rsp   (heap_rsp),
    .sum   (sum)
  );

  tkpt_avg u_avg (
    .clk     (clk),
    .sum     (sum),
    .average (average)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (heap_rsp.done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (heap_rsp.done) begin
      out_accepted <= heap_rsp.accepted;
      out_min      <= heap_rsp.min_kept;
      out_avg      <= average;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.accepted     = out_accepted;
  assign rsp.min_kept     = out_min;
  assign rsp.average_kept = out_avg;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the top-K peak tracker, with its own heap model.
module testbench;
  import tkpt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic                accepted;
    logic [SAMPLE_W-1:0] min_kept;
    logic [SAMPLE_W-1:0] average_kept;
  } peak_result_t;

  typedef struct {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    peak_result_t        result;
  } stim_row_t;

  logic clk;
  logic rst;

  tkpt_req_if req_ch ();
  tkpt_rsp_if rsp_ch ();

  top_k_peak_tracker u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Model state: the kept samples as a min-heap and their running sum
  logic [SAMPLE_W-1:0] kept_heap [KEEP_COUNT];
  logic [31:0]         kept_total;
  peak_result_t        pending_results [$];

  int error_count   = 0;
  int checked_count = 0;
  int sent_count    = 0;
  int query_count   = 0;
  int kept_count    = 0;
  int cycle_count   = 0;
  bit steady        = 1'b0;
  bit stall_request = 1'b0;
  bit stall_done    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one item to the heap model and return what the block must answer.
  function automatic peak_result_t predict_peak(input logic kind,
                                                input logic [SAMPLE_W-1:0] sample);
    peak_result_t        res;
    int                  pos;
    int                  kid;
    bit                  settled;
    logic [SAMPLE_W-1:0] moving;
    res.accepted = 1'b0;
    if (kind == KIND_INSERT && sample > kept_heap[0]) begin
      kept_total = kept_total - 32'(kept_heap[0]) + 32'(sample);
      moving  = sample;
      pos     = 0;
      settled = 1'b0;
      while (!settled && 2 * pos + 1 < KEEP_COUNT) begin
        kid = 2 * pos + 1;
        // take the right child only when strictly smaller
        if (kid + 1 < KEEP_COUNT && kept_heap[kid + 1] < kept_heap[kid]) kid++;
        if (kept_heap[kid] < moving) begin
          kept_heap[pos] = kept_heap[kid];
          pos = kid;
        end else begin
          settled = 1'b1;
        end
      end
      kept_heap[pos] = moving;
      res.accepted = 1'b1;
    end
    res.min_kept     = kept_heap[0];
    res.average_kept = SAMPLE_W'(kept_total / KEEP_COUNT);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // Offer one item, hold it until the transfer, then log the expected result.
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] sample,
                           input bit typed = 1'b0, input peak_result_t typed_res = '0);
    peak_result_t res;
    if (!steady && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.kind   <= kind;
    req_ch.sample <= sample;
    do @(posedge clk); while (!req_ch.ready);
    res = predict_peak(kind, sample);
    pending_results.push_back(typed ? typed_res : res);
    sent_count++;
    if (kind == KIND_QUERY) query_count++;
    if (res.accepted) kept_count++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    stim_row_t directed [13] = '{
      '{KIND_QUERY,  16'h0000, 1'b1, '{1'b0, 16'd0, 16'd0}},
      '{KIND_QUERY,  16'hFFFF, 1'b1, '{1'b0, 16'd0, 16'd0}},
      '{KIND_INSERT, 16'h0000, 1'b1, '{1'b0, 16'd0, 16'd0}},
      '{KIND_INSERT, 16'hFFFF, 1'b1, '{1'b1, 16'd0, 16'd655}},
      '{KIND_INSERT, 16'h0001, 1'b1, '{1'b1, 16'd0, 16'd655}},
      '{KIND_QUERY,  16'hAAAA, 1'b1, '{1'b0, 16'd0, 16'd655}},
      '{KIND_INSERT, 16'h5555, 1'b0, '{1'b0, 16'd0, 16'd0}},
      '{KIND_INSERT, 16'h8000, 1'b0, '{1'b0, 16'd0, 16'd0}},
      '{KIND_INSERT, 16'h7FFF, 1'b0, '{1'b0, 16'd0, 16'd0}},
      '{KIND_INSERT, 16'hFFFF, 1'b0, '{1'b0, 16'd0, 16'd0}},
      '{KIND_QUERY,  16'h5555, 1'b0, '{1'b0, 16'd0, 16'd0}},
      '{KIND_INSERT, 16'h0000, 1'b0, '{1'b0, 16'd0, 16'd0}},
      '{KIND_INSERT, 16'h0001, 1'b0, '{1'b0, 16'd0, 16'd0}}
    };
    req_ch.valid  <= 1'b0;
    req_ch.kind   <= KIND_INSERT;
    req_ch.sample <= '0;
    rst           <= 1'b1;
    foreach (kept_heap[i]) kept_heap[i] = '0;
    kept_total = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_item(directed[i].kind, directed[i].sample, directed[i].typed, directed[i].result);

    // Few distinct values: the heap fills with ties
    for (int i = 0; i < 120; i++) begin
      kind   = ($urandom_range(0, 7) == 0) ? KIND_QUERY : KIND_INSERT;
      sample = (kind == KIND_QUERY) ? SAMPLE_W'($urandom)
                                    : SAMPLE_W'(1000 + 8 * $urandom_range(0, 7));
      send_item(kind, sample);
    end

    // Wide values around the current minimum; the receiver holds off early on
    stall_request = 1'b1;
    for (int i = 0; i < 250; i++) begin
      kind = ($urandom_range(0, 5) == 0) ? KIND_QUERY : KIND_INSERT;
      case ($urandom_range(0, 4))
        0:       sample = SAMPLE_W'($urandom);
        1:       sample = kept_heap[0];
        2:       sample = kept_heap[0] + 1'b1;
        3:       sample = kept_heap[0] - 1'b1;
        default: sample = SAMPLE_W'($urandom_range(40000, 65535));
      endcase
      send_item(kind, sample);
    end

    // Back-to-back near full scale, driving the average toward its ceiling
    steady = 1'b1;
    for (int i = 0; i < 160; i++) begin
      kind = ($urandom_range(0, 9) == 0) ? KIND_QUERY : KIND_INSERT;
      if (kind == KIND_QUERY)            sample = SAMPLE_W'($urandom);
      else if ($urandom_range(0, 3) != 0) sample = 16'hFFFF;
      else                               sample = SAMPLE_W'($urandom_range(65000, 65535));
      send_item(kind, sample);
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d items (%0d queries, %0d samples kept), checked %0d results.",
             sent_count, query_count, kept_count, checked_count);
    $display("Receiver held off %0d cycles once; final minimum %0d, average %0d.",
             stall_done ? STALL_CYCLES : 0, kept_heap[0], kept_total / KEEP_COUNT);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int held;
    rsp_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_request && !stall_done) begin
        // hold off long enough for the block to back up into its input
        rsp_ch.ready <= 1'b0;
        held = 0;
        while (held < STALL_CYCLES) begin
          @(negedge clk);
          held++;
        end
        stall_done = 1'b1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    peak_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending (min %0d avg %0d)",
                                  rsp_ch.min_kept, rsp_ch.average_kept));
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (rsp_ch.accepted !== want.accepted)
          report_mismatch($sformatf("result %0d accepted %b, want %b",
                                    checked_count, rsp_ch.accepted, want.accepted));
        if (rsp_ch.min_kept !== want.min_kept)
          report_mismatch($sformatf("result %0d min_kept %0d, want %0d",
                                    checked_count, rsp_ch.min_kept, want.min_kept));
        if (rsp_ch.average_kept !== want.average_kept)
          report_mismatch($sformatf("result %0d average_kept %0d, want %0d",
                                    checked_count, rsp_ch.average_kept, want.average_kept));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results pending.",
             cycle_count, pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tkpt_pkg.sv
rtl/core/tkpt_if.sv
rtl/core/tkpt_ram.sv
rtl/core/tkpt_heap.sv
rtl/core/tkpt_avg.sv
rtl/core/top_k_peak_tracker.sv
verif/testbench.sv
